/* design/uped_pkg.sv */
// Shared types and codes for the URI path extract decoder.
// No dependencies; used by every module in design/.
package uped_pkg;

  // Parser phases (plain vector codes)
  localparam logic [2:0] PH_FIRST  = 3'd0;
  localparam logic [2:0] PH_SCHEME = 3'd1;
  localparam logic [2:0] PH_COLON  = 3'd2;
  localparam logic [2:0] PH_AUTH   = 3'd3;
  localparam logic [2:0] PH_PATH   = 3'd4;
  localparam logic [2:0] PH_TAIL   = 3'd5;
  localparam logic [2:0] PH_STOP   = 3'd6;

  // Result kinds
  localparam logic [1:0] K_NONE   = 2'd0;
  localparam logic [1:0] K_SCHEME = 2'd1;
  localparam logic [1:0] K_AUTH   = 2'd2;
  localparam logic [1:0] K_PATH   = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_SCHEME = 3'd1;
  localparam logic [2:0] ST_NO_COLON   = 3'd2;
  localparam logic [2:0] ST_AUTH_OPEN  = 3'd3;
  localparam logic [2:0] ST_AUTH_START = 3'd4;
  localparam logic [2:0] ST_ESC_SHORT  = 3'd5;
  localparam logic [2:0] ST_BAD_HEX    = 3'd6;

  // Characters
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;

  // Result queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoLw    = FifoAw + 1;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       done;
    logic [2:0] status;
    logic       last;
  } res_t;

  // Core -> queue push bundle
  typedef struct packed {
    logic [1:0] count;  // 0..2 results this cycle
    res_t       r0;
    res_t       r1;
  } push_t;

  // Queue status toward the top level
  typedef struct packed {
    logic [FifoLw-1:0] level;
    logic              room2;  // space for two more results
  } fifo_stat_t;

endpackage

/* design/uped_core.sv */
// Parser state and per-item step logic: one held byte in, up to two results out.
// Depends on uped_pkg.
module uped_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             step_i,     // held item is consumed this cycle
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output uped_pkg::push_t  push_o
);

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic [1:0] esc;
    logic [3:0] hn;
    logic       tail;
    logic [2:0] fail_code;
  } pb_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic pb_t path_byte(input logic [7:0] c, input logic [1:0] esc,
                                    input logic [3:0] hn);
    pb_t        p;
    logic       term;
    logic [4:0] hv;
    term = (c == uped_pkg::CH_QUEST) || (c == uped_pkg::CH_HASH);
    hv   = hex_value(c);
    p.emit = 1'b0;
    p.data = c;
    p.esc  = esc;
    p.hn   = hn;
    p.tail = 1'b0;
    p.fail_code = uped_pkg::ST_OK;
    case (esc)
      2'd0: begin
        if (c == uped_pkg::CH_PERCENT) p.esc = 2'd1;
        else if (term) p.tail = 1'b1;
        else p.emit = 1'b1;
      end
      2'd1: begin
        if (term) p.fail_code = uped_pkg::ST_ESC_SHORT;
        else if (!hv[4]) p.esc = 2'd3;
        else begin
          p.hn  = hv[3:0];
          p.esc = 2'd2;
        end
      end
      2'd2: begin
        if (term) p.fail_code = uped_pkg::ST_ESC_SHORT;
        else if (!hv[4]) p.fail_code = uped_pkg::ST_BAD_HEX;
        else begin
          p.emit = 1'b1;
          p.data = {hn, hv[3:0]};
          p.esc  = 2'd0;
        end
      end
      default: begin
        p.fail_code = term ? uped_pkg::ST_ESC_SHORT : uped_pkg::ST_BAD_HEX;
      end
    endcase
    return p;
  endfunction

  logic       drop_q;
  logic [2:0] phase_q, phase_d;
  logic       sp_q, sp_d;
  logic [1:0] esc_q, esc_d;
  logic [3:0] hn_q, hn_d;
  logic [2:0] err_q, err_d;

  logic [1:0] cnt;
  logic [1:0] kk [2];
  logic [7:0] dd [2];
  pb_t        pb;
  logic       is_let, is_dig;

  always_comb begin
    phase_d = phase_q;
    sp_d    = sp_q;
    esc_d   = esc_q;
    hn_d    = hn_q;
    err_d   = err_q;
    cnt     = 2'd0;
    kk[0]   = uped_pkg::K_NONE;
    kk[1]   = uped_pkg::K_NONE;
    dd[0]   = 8'd0;
    dd[1]   = 8'd0;
    is_let  = (byte_i >= 8'h41 && byte_i <= 8'h5A) || (byte_i >= 8'h61 && byte_i <= 8'h7A);
    is_dig  = (byte_i >= 8'h30 && byte_i <= 8'h39);
    pb      = path_byte(byte_i, esc_q, hn_q);

    case (phase_q)
      uped_pkg::PH_FIRST: begin
        if (is_let) begin
          kk[cnt[0]] = uped_pkg::K_SCHEME;
          dd[cnt[0]] = byte_i;
          cnt = cnt + 2'd1;
          phase_d = uped_pkg::PH_SCHEME;
        end else begin
          err_d = uped_pkg::ST_BAD_SCHEME;
          phase_d = uped_pkg::PH_STOP;
          sp_d = 1'b0;
        end
      end
      uped_pkg::PH_SCHEME: begin
        if (byte_i == uped_pkg::CH_COLON) phase_d = uped_pkg::PH_COLON;
        else if (is_let || is_dig || byte_i == uped_pkg::CH_PLUS ||
                 byte_i == uped_pkg::CH_MINUS || byte_i == uped_pkg::CH_DOT) begin
          kk[cnt[0]] = uped_pkg::K_SCHEME;
          dd[cnt[0]] = byte_i;
          cnt = cnt + 2'd1;
        end else begin
          err_d = uped_pkg::ST_BAD_SCHEME;
          phase_d = uped_pkg::PH_STOP;
          sp_d = 1'b0;
        end
      end
      uped_pkg::PH_COLON: begin
        if (sp_q) begin
          sp_d = 1'b0;
          if (byte_i == uped_pkg::CH_SLASH) phase_d = uped_pkg::PH_AUTH;
          else begin
            // single slash: it opens the path, this byte is the first path byte
            if (!drop_q) begin
              kk[cnt[0]] = uped_pkg::K_PATH;
              dd[cnt[0]] = uped_pkg::CH_SLASH;
              cnt = cnt + 2'd1;
            end
            phase_d = uped_pkg::PH_PATH;
            if (pb.emit) begin
              kk[cnt[0]] = uped_pkg::K_PATH;
              dd[cnt[0]] = pb.data;
              cnt = cnt + 2'd1;
            end
            esc_d = pb.esc;
            hn_d  = pb.hn;
            if (pb.tail) phase_d = uped_pkg::PH_TAIL;
            if (pb.fail_code != uped_pkg::ST_OK) begin
              err_d = pb.fail_code;
              phase_d = uped_pkg::PH_STOP;
            end
          end
        end else if (byte_i == uped_pkg::CH_SLASH) begin
          sp_d = 1'b1;
        end else begin
          err_d = uped_pkg::ST_AUTH_START;
          phase_d = uped_pkg::PH_STOP;
          sp_d = 1'b0;
        end
      end
      uped_pkg::PH_AUTH: begin
        if (byte_i == uped_pkg::CH_SLASH) begin
          if (!drop_q) begin
            kk[cnt[0]] = uped_pkg::K_PATH;
            dd[cnt[0]] = uped_pkg::CH_SLASH;
            cnt = cnt + 2'd1;
          end
          phase_d = uped_pkg::PH_PATH;
        end else begin
          kk[cnt[0]] = uped_pkg::K_AUTH;
          dd[cnt[0]] = byte_i;
          cnt = cnt + 2'd1;
        end
      end
      uped_pkg::PH_PATH: begin
        if (pb.emit) begin
          kk[cnt[0]] = uped_pkg::K_PATH;
          dd[cnt[0]] = pb.data;
          cnt = cnt + 2'd1;
        end
        esc_d = pb.esc;
        hn_d  = pb.hn;
        if (pb.tail) phase_d = uped_pkg::PH_TAIL;
        if (pb.fail_code != uped_pkg::ST_OK) begin
          err_d = pb.fail_code;
          phase_d = uped_pkg::PH_STOP;
          sp_d = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (last_i) begin
      if (err_d == uped_pkg::ST_OK) begin
        case (phase_d)
          uped_pkg::PH_SCHEME: err_d = uped_pkg::ST_NO_COLON;
          uped_pkg::PH_COLON: begin
            if (sp_d) begin
              // URI ends at a lone slash: the path is "/"
              if (!drop_q) begin
                kk[cnt[0]] = uped_pkg::K_PATH;
                dd[cnt[0]] = uped_pkg::CH_SLASH;
                cnt = cnt + 2'd1;
              end
            end else begin
              err_d = uped_pkg::ST_AUTH_START;
            end
          end
          uped_pkg::PH_AUTH: err_d = uped_pkg::ST_AUTH_OPEN;
          uped_pkg::PH_PATH: begin
            if (esc_d != 2'd0) err_d = uped_pkg::ST_ESC_SHORT;
          end
          uped_pkg::PH_FIRST: err_d = uped_pkg::ST_BAD_SCHEME;
          default: begin
          end
        endcase
      end
      if (cnt == 2'd0) begin
        kk[0] = uped_pkg::K_NONE;
        dd[0] = 8'd0;
        cnt   = 2'd1;
      end
    end

    push_o.count     = cnt;
    push_o.r0.kind   = kk[0];
    push_o.r0.data   = dd[0];
    push_o.r0.done   = last_i && (cnt == 2'd1);
    push_o.r0.status = (last_i && (cnt == 2'd1)) ? err_d : uped_pkg::ST_OK;
    push_o.r0.last   = (cnt == 2'd1);
    push_o.r1.kind   = kk[1];
    push_o.r1.data   = dd[1];
    push_o.r1.done   = last_i;
    push_o.r1.status = last_i ? err_d : uped_pkg::ST_OK;
    push_o.r1.last   = 1'b1;

    // end of URI: parser state back to its start
    if (last_i) begin
      phase_d = uped_pkg::PH_FIRST;
      sp_d    = 1'b0;
      esc_d   = 2'd0;
      hn_d    = 4'd0;
      err_d   = uped_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q  <= 1'b0;
      phase_q <= uped_pkg::PH_FIRST;
      sp_q    <= 1'b0;
      esc_q   <= 2'd0;
      hn_q    <= 4'd0;
      err_q   <= uped_pkg::ST_OK;
    end else begin
      if (cfg_we_i) drop_q <= cfg_wdata_i;
      if (step_i) begin
        phase_q <= phase_d;
        sp_q    <= sp_d;
        esc_q   <= esc_d;
        hn_q    <= hn_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

/* design/uped_out_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per cycle on each pop.
// Depends on uped_pkg.
module uped_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_en_i,
  input  uped_pkg::push_t     push_i,
  input  logic                pop_i,
  output uped_pkg::res_t      head_o,
  output logic                nonempty_o,
  output uped_pkg::fifo_stat_t stat_o
);

  localparam int unsigned Aw = uped_pkg::FifoAw;
  localparam int unsigned Lw = uped_pkg::FifoLw;

  uped_pkg::res_t mem_q [uped_pkg::FifoDepth];
  logic [Aw-1:0]  wptr_q, rptr_q;
  logic [Lw-1:0]  level_q;
  logic [1:0]     n_push;

  assign n_push = push_en_i ? push_i.count : 2'd0;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wptr_q] <= push_i.r0;
    if (n_push == 2'd2) mem_q[wptr_q + Aw'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_q + Aw'(n_push);
      if (pop_i) rptr_q <= rptr_q + Aw'(1);
      level_q <= level_q + Lw'(n_push) - Lw'(pop_i);
    end
  end

  assign head_o       = mem_q[rptr_q];
  assign nonempty_o   = (level_q != '0);
  assign stat_o.level = level_q;
  assign stat_o.room2 = (level_q <= Lw'(uped_pkg::FifoDepth - 2));

endmodule

/* design/uri_path_extract_decoder.sv */
// Top level of the URI path extract decoder: input register, parser core, result queue.
// Depends on uped_pkg, uped_core, uped_out_fifo.
//
// Usage: URI text enters one byte per item on the s_axis channel, s_axis_tlast on
// its final byte. Each item yields zero, one or two results on m_axis: scheme,
// authority or decoded path bytes tagged by m_axis_tuser, and on the URI's final
// byte a result with m_axis_tlast set and the status in m_axis_tdata.
// A result reaches m_axis after its byte has passed the input register and has been
// written into the result queue.
// Throughput: one byte per cycle while each byte gives at most one result and
// m_axis_tready stays high; a byte that gives two results adds one more result
// for the single-result output port to drain from the four-entry result queue.
// The input register and the queue keep the input side moving while a result
// waits: when m_axis_tready is low the queue fills, and once fewer than two
// entries are free the held byte waits and s_axis_tready drops. Nothing is lost.
// Reset empties the queue and input register, returns the parser to the start
// of a URI and clears drop_first_path_slash (cfg_we_i / cfg_wdata_i), which the user
// must write only while the block is idle; the block itself does not enforce it.
module uri_path_extract_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] out_status, [11] out_last
  output logic        m_axis_tlast,   // out_done
  output logic [1:0]  m_axis_tuser    // [1:0] out_kind
);

  logic                 in_v_q;
  logic [7:0]           in_byte_q;
  logic                 in_last_q;
  logic                 step;
  logic                 pop;
  uped_pkg::push_t      push;
  uped_pkg::res_t       head;
  uped_pkg::fifo_stat_t fstat;
  logic                 nonempty;

  assign step          = in_v_q && fstat.room2;
  assign s_axis_tready = !in_v_q || step;
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  uped_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .push_o      (push)
  );

  uped_out_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_en_i  (step),
    .push_i     (push),
    .pop_i      (pop),
    .head_o     (head),
    .nonempty_o (nonempty),
    .stat_o     (fstat)
  );

  assign m_axis_tvalid = nonempty;
  assign m_axis_tdata  = {4'd0, head.last, head.status, head.data};
  assign m_axis_tlast  = head.done;
  assign m_axis_tuser  = head.kind;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.level <= uped_pkg::FifoLw'(uped_pkg::FifoDepth))
    else $error("result queue overflow");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && !step |=> in_v_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("held item lost while stalled");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[11])
    else $error("final result not marked last of its item");

  a_status_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[10:8] != uped_pkg::ST_OK) |-> m_axis_tlast)
    else $error("status on a non-final result");
`endif

endmodule
